// ----- rtl/mf_pkg.sv -----
// shared types, constants and compare helpers for the 3x3 median filter
// no dependencies; imported by mf_front, mf_back and the top level
package mf_pkg;

  localparam int MF_PIXEL_BITS    = 8;
  localparam int MF_COORD_BITS    = 10;
  localparam int MF_CFG_BITS      = 11;
  localparam int MF_CFG_IDX_BITS  = 1;
  localparam int MF_MAX_WIDTH     = 1024;
  localparam int MF_MAX_HEIGHT    = 1024;
  localparam int MF_QUEUE_DEPTH   = 4;
  localparam int MF_RESET_WIDTH   = 640;
  localparam int MF_RESET_HEIGHT  = 480;
  localparam int MF_MIN_DIM       = 3;

  // result slots of one transaction, in emission order
  localparam int MF_SLOTS       = 4;
  localparam int SLOT_CENTRE    = 0;  // (r-1, c-1)
  localparam int SLOT_RIGHT     = 1;  // (r-1, c) at end of row
  localparam int SLOT_BELOW     = 2;  // (r, c-1) on last row
  localparam int SLOT_CORNER    = 3;  // (r, c) last pixel of the frame

  typedef enum logic [MF_CFG_IDX_BITS-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef logic [MF_PIXEL_BITS-1:0] pix_t;
  typedef logic [MF_COORD_BITS-1:0] coord_t;

  typedef struct packed {
    pix_t lo;
    pix_t mid;
    pix_t hi;
  } triple_t;

  // one classified window handed from front to back
  typedef struct packed {
    pix_t                lo_max;
    pix_t                mid_med;
    pix_t                hi_min;
    pix_t                w11;
    pix_t                w12;
    pix_t                w21;
    pix_t                w22;
    coord_t              row;
    coord_t              col;
    logic                inner;
    logic [MF_SLOTS-1:0] mask;
  } mf_job_t;

  function automatic pix_t pmin(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t pmax(pix_t a, pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic triple_t sort3(pix_t a, pix_t b, pix_t c);
    pix_t    lo_ab;
    pix_t    hi_ab;
    pix_t    t;
    triple_t s;
    lo_ab = pmin(a, b);
    hi_ab = pmax(a, b);
    t     = pmax(lo_ab, c);
    s.lo  = pmin(lo_ab, c);
    s.mid = pmin(hi_ab, t);
    s.hi  = pmax(hi_ab, t);
    return s;
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return pmax(pmin(a, b), pmin(pmax(a, b), c));
  endfunction

endpackage

// ----- rtl/mf_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module mf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    // read data holds while no read is issued
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/mf_front.sv -----
// front part: config registers, raster position, line buffer, window and first median stages
// depends on mf_pkg and mf_ram
module mf_front #(
  parameter int MAX_WIDTH  = mf_pkg::MF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mf_pkg::MF_MAX_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [mf_pkg::MF_CFG_IDX_BITS-1:0] cfg_index,
  input  logic [mf_pkg::MF_CFG_BITS-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [mf_pkg::MF_PIXEL_BITS-1:0]   in_pixel,
  output logic                               job_valid,
  input  logic                               job_ready,
  output mf_pkg::mf_job_t                    job
);

  import mf_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int CWX   = ((CW + 1) > MF_CFG_BITS) ? (CW + 1) : MF_CFG_BITS;
  localparam int RWX   = ((RW + 1) > MF_CFG_BITS) ? (RW + 1) : MF_CFG_BITS;
  localparam int RST_W = (MF_RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : MF_RESET_WIDTH;
  localparam int RST_H = (MF_RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : MF_RESET_HEIGHT;
  localparam logic [CW-1:0] RST_W_M1 = CW'(RST_W - 1);
  localparam logic [RW-1:0] RST_H_M1 = RW'(RST_H - 1);

  typedef struct packed {
    coord_t              row10;
    coord_t              col10;
    logic                inner;
    logic [MF_SLOTS-1:0] mask;
  } meta_t;

  typedef struct packed {
    pix_t          pix;
    logic [CW-1:0] col;
    logic          row_ge1;
    logic          row_ge2;
    meta_t         meta;
  } s1_t;

  // clamped dimensions, stored as last index
  logic [CW-1:0]  w_m1_r, w_m1_nxt;
  logic [RW-1:0]  h_m1_r, h_m1_nxt;
  logic [CWX-1:0] w_cfg, w_cl;
  logic [RWX-1:0] h_cfg, h_cl;

  logic [CW-1:0]  col_r, col_nxt, col0;
  logic [RW-1:0]  row_r, row_nxt, row0;
  logic           restart, eor, lastrow, col_ge1, col_ge2;
  logic           in_fire;

  logic           s1_valid_r, s1_valid_nxt, s1_adv, s1_free;
  s1_t            s1_r, s1_nxt;
  logic           s2_valid_r, s2_valid_nxt, s2_adv, s2_free;
  meta_t          s2_r;
  logic           s3_valid_r, s3_valid_nxt, s3_free;
  meta_t          s3_r;

  logic [2*MF_PIXEL_BITS-1:0] ram_rdata;
  pix_t           up1, up2;
  pix_t           win_r [3][3];
  triple_t        srt_r [3];
  pix_t           w11_r, w12_r, w21_r, w22_r;

  always_comb begin
    w_cfg    = CWX'(cfg_data);
    h_cfg    = RWX'(cfg_data);
    w_cl     = (w_cfg < CWX'(MF_MIN_DIM)) ? CWX'(MF_MIN_DIM) :
               (w_cfg > CWX'(MAX_WIDTH))  ? CWX'(MAX_WIDTH)  : w_cfg;
    h_cl     = (h_cfg < RWX'(MF_MIN_DIM)) ? RWX'(MF_MIN_DIM) :
               (h_cfg > RWX'(MAX_HEIGHT)) ? RWX'(MAX_HEIGHT) : h_cfg;
    w_m1_nxt = w_m1_r;
    h_m1_nxt = h_m1_r;
    if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:  w_m1_nxt = CW'(w_cl - CWX'(1));
        CFG_IMAGE_HEIGHT: h_m1_nxt = RW'(h_cl - RWX'(1));
        default: ;
      endcase
    end
  end

  // handshake chain through the stages
  always_comb begin
    job_valid = s3_valid_r && (|s3_r.mask);
    s3_free   = !s3_valid_r || !(|s3_r.mask) || job_ready;
    s2_adv    = s2_valid_r && s3_free;
    s2_free   = !s2_valid_r || s3_free;
    s1_adv    = s1_valid_r && s2_free;
    s1_free   = !s1_valid_r || s2_free;
    in_ready  = s1_free;
    in_fire   = in_valid && in_ready;

    s1_valid_nxt = in_fire ? 1'b1 : (s2_free ? 1'b0 : s1_valid_r);
    s2_valid_nxt = s1_adv  ? 1'b1 : (s3_free ? 1'b0 : s2_valid_r);
    s3_valid_nxt = s2_adv  ? 1'b1 : (s3_free ? 1'b0 : s3_valid_r);
  end

  // position and classification of the incoming pixel
  always_comb begin
    restart = (col_r > w_m1_r) || (row_r > h_m1_r);
    col0    = restart ? '0 : col_r;
    row0    = restart ? '0 : row_r;
    eor     = (col0 == w_m1_r);
    lastrow = (row0 == h_m1_r);
    col_ge1 = (col0 != '0);
    col_ge2 = (col0 > CW'(1));

    s1_nxt.pix        = in_pixel;
    s1_nxt.col        = col0;
    s1_nxt.row_ge1    = (row0 != '0);
    s1_nxt.row_ge2    = (row0 > RW'(1));
    s1_nxt.meta.row10 = coord_t'(row0);
    s1_nxt.meta.col10 = coord_t'(col0);
    s1_nxt.meta.inner = s1_nxt.row_ge2 && col_ge2;
    s1_nxt.meta.mask[SLOT_CENTRE] = s1_nxt.row_ge1 && col_ge1;
    s1_nxt.meta.mask[SLOT_RIGHT]  = s1_nxt.row_ge1 && eor;
    s1_nxt.meta.mask[SLOT_BELOW]  = lastrow && col_ge1;
    s1_nxt.meta.mask[SLOT_CORNER] = lastrow && eor;

    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire) begin
      col_nxt = eor ? '0 : col0 + 1'b1;
      row_nxt = eor ? (lastrow ? '0 : row0 + 1'b1) : row0;
    end
  end

  // line buffer entry holds {two rows up, one row up} for each column
  mf_ram #(
    .WIDTH (2 * MF_PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_r.col),
    .wdata ({up1, s1_r.pix}),
    .re    (in_fire),
    .raddr (col0),
    .rdata (ram_rdata)
  );

  assign up1 = s1_r.row_ge1 ? ram_rdata[MF_PIXEL_BITS-1:0] : '0;
  assign up2 = s1_r.row_ge2 ? ram_rdata[2*MF_PIXEL_BITS-1:MF_PIXEL_BITS] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_m1_r     <= RST_W_M1;
      h_m1_r     <= RST_H_M1;
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      w_m1_r     <= w_m1_nxt;
      h_m1_r     <= h_m1_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      s3_valid_r <= s3_valid_nxt;
    end
  end

  // window shifts once per pixel, so it always matches the item in stage two
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
    if (s1_adv) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= up2;
      win_r[1][2] <= up1;
      win_r[2][2] <= s1_r.pix;
      s2_r        <= s1_r.meta;
    end
    if (s2_adv) begin
      for (int j = 0; j < 3; j++) begin
        srt_r[j] <= sort3(win_r[0][j], win_r[1][j], win_r[2][j]);
      end
      w11_r <= win_r[1][1];
      w12_r <= win_r[1][2];
      w21_r <= win_r[2][1];
      w22_r <= win_r[2][2];
      s3_r  <= s2_r;
    end
  end

  always_comb begin
    job.lo_max  = pmax(pmax(srt_r[0].lo, srt_r[1].lo), srt_r[2].lo);
    job.mid_med = med3(srt_r[0].mid, srt_r[1].mid, srt_r[2].mid);
    job.hi_min  = pmin(pmin(srt_r[0].hi, srt_r[1].hi), srt_r[2].hi);
    job.w11     = w11_r;
    job.w12     = w12_r;
    job.w21     = w21_r;
    job.w22     = w22_r;
    job.row     = s3_r.row10;
    job.col     = s3_r.col10;
    job.inner   = s3_r.inner;
    job.mask    = s3_r.mask;
  end

endmodule

// ----- rtl/mf_queue.sv -----
// small show-ahead fifo in flip-flops between front and back
// no dependencies
module mf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW  = $clog2(DEPTH);
  localparam int CTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CTW-1:0]   cnt_r, cnt_nxt;
  logic             push, pop;

  always_comb begin
    push_ready = (cnt_r != CTW'(DEPTH));
    pop_valid  = (cnt_r != '0);
    pop_data   = mem_r[rd_ptr_r];
    push       = push_valid && push_ready;
    pop        = pop_valid && pop_ready;

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end

    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/mf_back.sv -----
// back part: final median step and one result per cycle into the output register
// unless out_ready stalls it; depends on mf_pkg
module mf_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             job_valid,
  output logic                             job_ready,
  input  mf_pkg::mf_job_t                  job,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mf_pkg::MF_PIXEL_BITS-1:0] out_pixel_out,
  output logic [mf_pkg::MF_COORD_BITS-1:0] out_row,
  output logic [mf_pkg::MF_COORD_BITS-1:0] out_col,
  output logic                             out_frame_last
);

  import mf_pkg::*;

  mf_job_t             cur_r;
  logic                cur_valid_r, cur_valid_nxt;
  logic [MF_SLOTS-1:0] sel, left;
  logic                load_out, emit, pop;
  pix_t                med;
  pix_t                res_pix;
  coord_t              res_row, res_col;
  logic                res_last;

  logic                out_valid_r, out_valid_nxt;
  pix_t                out_pix_r;
  coord_t              out_row_r, out_col_r;
  logic                out_last_r;

  always_comb begin
    load_out = !out_valid_r || out_ready;
    emit     = cur_valid_r && load_out;

    // lowest pending slot goes first
    sel = '0;
    if (cur_r.mask[SLOT_CENTRE]) begin
      sel[SLOT_CENTRE] = 1'b1;
    end else if (cur_r.mask[SLOT_RIGHT]) begin
      sel[SLOT_RIGHT] = 1'b1;
    end else if (cur_r.mask[SLOT_BELOW]) begin
      sel[SLOT_BELOW] = 1'b1;
    end else begin
      sel[SLOT_CORNER] = 1'b1;
    end
    left = cur_r.mask & ~sel;

    job_ready     = !cur_valid_r || (emit && (left == '0));
    pop           = job_valid && job_ready;
    cur_valid_nxt = pop ? 1'b1 : (emit ? (|left) : cur_valid_r);
    out_valid_nxt = load_out ? emit : out_valid_r;

    med = med3(cur_r.lo_max, cur_r.mid_med, cur_r.hi_min);

    res_last = 1'b0;
    if (sel[SLOT_CENTRE]) begin
      res_pix = cur_r.inner ? med : cur_r.w11;
      res_row = cur_r.row - 1'b1;
      res_col = cur_r.col - 1'b1;
    end else if (sel[SLOT_RIGHT]) begin
      res_pix = cur_r.w12;
      res_row = cur_r.row - 1'b1;
      res_col = cur_r.col;
    end else if (sel[SLOT_BELOW]) begin
      res_pix = cur_r.w21;
      res_row = cur_r.row;
      res_col = cur_r.col - 1'b1;
    end else begin
      res_pix  = cur_r.w22;
      res_row  = cur_r.row;
      res_col  = cur_r.col;
      res_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= job;
    end else if (emit) begin
      cur_r.mask <= left;
    end
    if (emit) begin
      out_pix_r  <= res_pix;
      out_row_r  <= res_row;
      out_col_r  <= res_col;
      out_last_r <= res_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_out  = out_pix_r;
  assign out_row        = out_row_r;
  assign out_col        = out_col_r;
  assign out_frame_last = out_last_r;

endmodule

// ----- rtl/median_filter_3x3.sv -----
// top level of the 3x3 median filter: front, queue and back
// depends on mf_pkg, mf_front (with mf_ram), mf_queue and mf_back
//
// 3x3 median filter over a raster-order stream of grey pixels. one pixel
// transaction is accepted per clock unless in_ready is low. it reads the
// line buffer (one ram of MAX_WIDTH entries, each holding the two rows
// above) and passes the line buffer read, the window register and the
// registered column sort before it is written into the queue. the back
// then loads it from the queue into its current-job register, and its first
// result goes from there into the output register. the back drains one
// result per clock into the output register unless out_ready stalls it; at
// row ends and on the last row a pixel can yield two or four results, the
// output port then sets the pace and the queue absorbs short bursts.
// interior pixels get the median of their nine neighbours, border pixels
// pass unchanged, and the bottom-right result carries out_frame_last. the
// line buffer needs no clearing after reset: an entry's data is only used
// for rows below one already written. width and height are clamped to
// 3..MAX_* and may only be changed while the block is idle
module median_filter_3x3 #(
  parameter int MAX_WIDTH   = mf_pkg::MF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = mf_pkg::MF_MAX_HEIGHT,
  parameter int QUEUE_DEPTH = mf_pkg::MF_QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration writes
  input  logic                               cfg_wr_en,
  input  logic [mf_pkg::MF_CFG_IDX_BITS-1:0] cfg_index,
  input  logic [mf_pkg::MF_CFG_BITS-1:0]     cfg_data,
  // pixel input
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [mf_pkg::MF_PIXEL_BITS-1:0]   in_pixel_in,
  // filtered results
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mf_pkg::MF_PIXEL_BITS-1:0]   out_pixel_out,
  output logic [mf_pkg::MF_COORD_BITS-1:0]   out_row,
  output logic [mf_pkg::MF_COORD_BITS-1:0]   out_col,
  output logic                               out_frame_last
);

  import mf_pkg::*;

  localparam int JOB_BITS = $bits(mf_job_t);

  // front to queue
  mf_job_t             front_job;
  logic                front_valid, front_ready;
  // queue to back
  logic [JOB_BITS-1:0] q_data;
  logic                q_valid, q_ready;
  mf_job_t             back_job;

  // position tracking, line buffer, window and first median stages
  mf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pixel  (in_pixel_in),
    .job_valid (front_valid),
    .job_ready (front_ready),
    .job       (front_job)
  );

  // decouples the pixel rate from the result rate
  mf_queue #(
    .WIDTH (JOB_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  assign back_job = mf_job_t'(q_data);

  // serialises up to four results per window
  mf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_valid      (q_valid),
    .job_ready      (q_ready),
    .job            (back_job),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_out  (out_pixel_out),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_frame_last (out_frame_last)
  );

endmodule
